// File: design/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types, constants and helpers for the rotating server assigner.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int SRV_W       = 4;   // fixed by the server_index field
  localparam int K_W         = 5;
  localparam int TIME_W      = 32;
  localparam int END_W       = TIME_W + 1;
  localparam int CNT_W       = 32;
  localparam int KIND_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGNED = 2'd0,
    KIND_DROPPED  = 2'd1,
    KIND_REPORT   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_MAX,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [SRV_W-1:0] lowest_set(input logic [MAX_SERVERS-1:0] vec);
    logic [SRV_W-1:0] idx;
    idx = '0;
    for (int j = MAX_SERVERS - 1; j >= 0; j--) begin
      if (vec[j]) idx = SRV_W'(j);
    end
    return idx;
  endfunction

endpackage

// File: design/rsa_cell.sv
// ----------------------------------------------------------------------------
// rsa_cell
// One server: busy mark, end time and request count. Counts pass to the
// neighbouring cell when the chain rotates.
// ----------------------------------------------------------------------------
module rsa_cell
  import rsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic              wr,
  input  logic [TIME_W-1:0] arrival,
  input  logic [END_W-1:0]  new_end,
  input  logic [CNT_W-1:0]  count_in,
  output logic [CNT_W-1:0]  count_out,
  output logic              free
);

  logic             busy_r;
  logic [END_W-1:0] end_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
    end else if (ctrl.clear) begin
      busy_r  <= 1'b0;
      count_r <= '0;
    end else begin
      if (wr) busy_r <= 1'b1;
      if (ctrl.shift) begin
        count_r <= count_in;
      end else if (wr && (count_r != {CNT_W{1'b1}})) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) end_r <= new_end;
  end

  assign free      = !busy_r || (end_r <= {1'b0, arrival});
  assign count_out = count_r;

endmodule

// File: design/rsa_chain.sv
// ----------------------------------------------------------------------------
// rsa_chain
// Ring of server cells. On a shift each cell takes the count of the cell
// above it, so cell 0 shows every server's count in turn.
// ----------------------------------------------------------------------------
module rsa_chain
  import rsa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctrl_t             ctrl,
  input  logic [MAX_SERVERS-1:0] wr_sel,
  input  logic [TIME_W-1:0]      arrival,
  input  logic [END_W-1:0]       new_end,
  output logic [MAX_SERVERS-1:0] free,
  output logic [CNT_W-1:0]       head_count
);

  logic [CNT_W-1:0] count [MAX_SERVERS];

  for (genvar j = 0; j < MAX_SERVERS; j++) begin : g_cell
    rsa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .wr        (wr_sel[j]),
      .arrival   (arrival),
      .new_end   (new_end),
      .count_in  (count[(j + 1) % MAX_SERVERS]),
      .count_out (count[j]),
      .free      (free[j])
    );
  end

  assign head_count = count[0];

endmodule

// File: design/rotating_server_assigner.sv
// ----------------------------------------------------------------------------
// rotating_server_assigner
// Round-robin request assignment over a ring of server cells, with a
// busiest-server report at the end of each batch.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | arrival_time, load_time, batch_end
//   out     | output    | out_valid/out_stall | result_kind, server_index,
//           |           |                     | handled_count, run_last
//   cfg     | input     | cfg_wr_en           | cfg_wr_data (active servers)
//
// A request is accepted, then the free check, rotating pick and cell update
// are done together in the pick state. On a batch end the count ring then
// rotates once to find the maximum and once to report; output stalls hold it.
// Reset is synchronous; all servers idle with zero counts.
// Input stall is high while a request or report is in progress; an output
// stall holds the pick or report step until the output register frees.
// ----------------------------------------------------------------------------
module rotating_server_assigner
  import rsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] in_arrival_time,
  input  logic [TIME_W-1:0] in_load_time,
  input  logic              in_batch_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_result_kind,
  output logic [SRV_W-1:0]  out_server_index,
  output logic [CNT_W-1:0]  out_handled_count,
  output logic              out_run_last,
  input  logic              cfg_wr_en,
  input  logic [K_W-1:0]    cfg_wr_data
);

  state_t state_r, state_nxt;

  logic [TIME_W-1:0] arr_r, load_r;
  logic              last_r;
  logic [K_W-1:0]    k_r;
  logic [SRV_W-1:0]  ptr_r, ptr_nxt;
  logic [SRV_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]  best_r, best_nxt;
  logic [SRV_W-1:0]  last_idx_r, last_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [SRV_W-1:0]  out_idx_r, out_idx_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_last_r, out_last_nxt;

  cell_ctrl_t             ctrl;
  logic [MAX_SERVERS-1:0] wr_sel;
  logic [MAX_SERVERS-1:0] free;
  logic [CNT_W-1:0]       head_count;
  logic [END_W-1:0]       new_end;

  logic [K_W-1:0]         k_eff;
  logic [SRV_W-1:0]       p;
  logic [K_W-1:0]         p_inc;
  logic [MAX_SERVERS-1:0] cand_lo, cand_hi;
  logic                   found;
  logic [SRV_W-1:0]       pick;
  logic                   in_range;
  logic                   out_free;
  logic                   accept;
  logic                   last_step;

  assign k_eff = (k_r == '0) ? K_W'(1) :
                 (k_r > K_W'(MAX_SERVERS)) ? K_W'(MAX_SERVERS) : k_r;
  assign p     = ({1'b0, ptr_r} < k_eff) ? ptr_r : '0;
  assign p_inc = {1'b0, p} + K_W'(1);

  always_comb begin
    for (int j = 0; j < MAX_SERVERS; j++) begin
      cand_lo[j] = free[j] && (K_W'(j) < k_eff);
      cand_hi[j] = cand_lo[j] && (SRV_W'(j) >= p);
    end
  end

  assign found     = (cand_lo != '0);
  assign pick      = (cand_hi != '0) ? lowest_set(cand_hi) : lowest_set(cand_lo);
  assign new_end   = {1'b0, arr_r} + {1'b0, load_r};
  assign in_range  = ({1'b0, step_r} < k_eff);
  assign out_free  = !out_valid_r || !out_stall;
  assign accept    = in_valid && !in_stall;
  assign last_step = (step_r == SRV_W'(MAX_SERVERS - 1));
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    step_nxt      = step_r;
    best_nxt      = best_r;
    last_idx_nxt  = last_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;
    wr_sel        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (out_free) begin
          if (found) wr_sel = MAX_SERVERS'(1) << pick;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = found ? KIND_ASSIGNED : KIND_DROPPED;
          out_idx_nxt   = found ? pick : '0;
          out_cnt_nxt   = '0;
          out_last_nxt  = !last_r;
          ptr_nxt       = (p_inc >= k_eff) ? '0 : p_inc[SRV_W-1:0];
          if (last_r) begin
            state_nxt    = ST_MAX;
            step_nxt     = '0;
            best_nxt     = '0;
            last_idx_nxt = '0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MAX: begin
        ctrl.shift = 1'b1;
        if (in_range) begin
          if (head_count > best_r) begin
            best_nxt     = head_count;
            last_idx_nxt = step_r;
          end else if (head_count == best_r) begin
            last_idx_nxt = step_r;
          end
        end
        step_nxt = step_r + SRV_W'(1);
        if (last_step) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!(in_range && (head_count == best_r) && !out_free)) begin
          ctrl.shift = 1'b1;
          if (in_range && (head_count == best_r)) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_REPORT;
            out_idx_nxt   = step_r;
            out_cnt_nxt   = best_r;
            out_last_nxt  = (step_r == last_idx_r);
          end
          step_nxt = step_r + SRV_W'(1);
          if (last_step) begin
            ctrl.clear = 1'b1;
            ptr_nxt    = '0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= K_W'(MAX_SERVERS);
      ptr_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) k_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arr_r  <= in_arrival_time;
      load_r <= in_load_time;
      last_r <= in_batch_end;
    end
    best_r     <= best_nxt;
    last_idx_r <= last_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  rsa_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .wr_sel     (wr_sel),
    .arrival    (arr_r),
    .new_end    (new_end),
    .free       (free),
    .head_count (head_count)
  );

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_server_index  = out_idx_r;
  assign out_handled_count = out_cnt_r;
  assign out_run_last      = out_last_r;

endmodule

// File: design/rsa_checker.sv
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks for the rotating server assigner, bound to the top level.
// ----------------------------------------------------------------------------
module rsa_checker
  import rsa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [KIND_W-1:0] out_result_kind,
  input logic [SRV_W-1:0]  out_server_index,
  input logic [CNT_W-1:0]  out_handled_count,
  input logic              out_run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_server_index) && $stable(out_handled_count) && $stable(out_run_last))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while an item is in progress");

  a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_DROPPED) |->
      (out_server_index == '0) && (out_handled_count == '0))
    else $error("dropped item carries index or count");

  a_assigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_ASSIGNED) |-> (out_handled_count == '0))
    else $error("assigned item carries a count");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_kind == KIND_ASSIGNED) ||
      (out_result_kind == KIND_DROPPED) || (out_result_kind == KIND_REPORT)))
    else $error("unused result kind");

endmodule

bind rotating_server_assigner rsa_checker u_rsa_checker (.*);
